// File: sv/tmde_pkg.sv
package tmde_pkg;

   // Field and accumulator widths
   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = 48;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;

   // Largest group the counter follows before it saturates
   localparam int MAX_COUNT = 65535;

   // Smallest group that still has something left after trimming
   localparam int MIN_GROUP = 3;
   localparam int TRIM_DROP = 2;

   // Divider: one quotient bit per cycle over the whole dividend
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   // One finished group, handed from the front to the back
   typedef struct packed {
      logic signed [SUM_W-1:0]    sum;
      logic signed [SAMPLE_W-1:0] max;
      logic signed [SAMPLE_W-1:0] min;
      logic [COUNT_W-1:0]         divisor;
      logic [STATUS_W-1:0]        status;
   } job_type;

   // Back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_ABS,
      BK_DIV,
      BK_FIN
   } back_state_type;

endpackage

// File: sv/tmde_front.sv
module tmde_front
   import tmde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   input  logic                       q_full,
   output logic                       q_push,
   output job_type                    q_job
);

   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic                       accept;
   logic                       first;

   // Stall only while the queue has no room for a finished group
   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;
   assign first     = (count_ff == '0) & ~ovf_ff;

   // Running extremes, sum and count including the current beat
   always_comb begin
      max_in   = max_ff;
      min_in   = min_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (first) begin
         max_in = req_sample;
         min_in = req_sample;
      end else begin
         if (req_sample > max_ff) max_in = req_sample;
         if (req_sample < min_ff) min_in = req_sample;
      end
      if (count_ff == COUNT_W'(MAX_COUNT)) begin
         ovf_in = 1'b1;
      end else begin
         sum_in   = sum_ff + SUM_W'(req_sample);
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // Group summary for the back end
   always_comb begin
      q_job.sum     = sum_in;
      q_job.max     = max_in;
      q_job.min     = min_in;
      q_job.divisor = count_in - COUNT_W'(TRIM_DROP);
      priority if (ovf_in) begin
         q_job.status = STATUS_OVERFLOW;
      end else if (count_in < COUNT_W'(MIN_GROUP)) begin
         q_job.status = STATUS_SHORT;
      end else begin
         q_job.status = STATUS_OK;
      end
   end

   assign q_push = accept & req_last;

   // Accumulators clear after the marked beat
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         if (req_last) begin
            max_ff   <= '0;
            min_ff   <= '0;
            sum_ff   <= '0;
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            max_ff   <= max_in;
            min_ff   <= min_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

endmodule

// File: sv/tmde_queue.sv
module tmde_queue
   import tmde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  job_type wr_job,
   input  logic    pop,
   output logic    empty,
   output job_type rd_job
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff;
   logic [QPTR_W-1:0]   rptr_ff;
   logic [QPTR_W:0]     fill_ff;
   logic                do_push;
   logic                do_pop;

   assign full    = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_job  = slot_ff[rptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= wr_job;
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= wptr_ff + QPTR_W'(1);
         if (do_pop)  rptr_ff <= rptr_ff + QPTR_W'(1);
         if (do_push & ~do_pop)      fill_ff <= fill_ff + (QPTR_W+1)'(1);
         else if (do_pop & ~do_push) fill_ff <= fill_ff - (QPTR_W+1)'(1);
      end
   end

endmodule

// File: sv/tmde_back.sv
module tmde_back
   import tmde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  job_type                    q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_mean,
   output logic [STATUS_W-1:0]        rsp_status
);

   back_state_type             state_ff, state_in;
   job_type                    job_ff;
   logic signed [SUM_W-1:0]    trim_ff;
   logic                       neg_ff;
   logic [SUM_W-1:0]           quo_ff;
   logic [COUNT_W:0]           rem_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       valid_ff;
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic                       out_free;
   logic [COUNT_W:0]           rem_shift;
   logic                       take;
   logic [SUM_W-1:0]           quo_signed;

   assign out_free   = ~valid_ff | rsp_ready;
   assign rem_shift  = {rem_ff[COUNT_W-1:0], quo_ff[SUM_W-1]};
   assign take       = (rem_shift >= {1'b0, job_ff.divisor});
   assign quo_signed = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (~q_empty) begin
               q_pop    = 1'b1;
               state_in = (q_job.status == STATUS_OK) ? BK_PREP : BK_FIN;
            end
         end
         BK_PREP: state_in = BK_ABS;
         BK_ABS:  state_in = BK_DIV;
         BK_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = BK_FIN;
         end
         BK_FIN: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath: trim, take magnitude, restoring divide one bit a cycle
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (~q_empty) job_ff <= q_job;
         end
         BK_PREP: begin
            trim_ff <= job_ff.sum - SUM_W'(job_ff.max) - SUM_W'(job_ff.min);
         end
         BK_ABS: begin
            neg_ff  <= trim_ff[SUM_W-1];
            quo_ff  <= trim_ff[SUM_W-1] ? (~trim_ff + SUM_W'(1)) : trim_ff;
            rem_ff  <= '0;
            step_ff <= '0;
         end
         BK_DIV: begin
            rem_ff  <= take ? (rem_shift - {1'b0, job_ff.divisor}) : rem_shift;
            quo_ff  <= {quo_ff[SUM_W-2:0], take};
            step_ff <= step_ff + STEP_W'(1);
         end
         BK_FIN: ;
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (state_ff == BK_FIN && out_free) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_FIN && out_free) begin
         status_ff <= job_ff.status;
         mean_ff   <= (job_ff.status == STATUS_OK) ? quo_signed[SAMPLE_W-1:0] : '0;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_mean   = mean_ff;
   assign rsp_status = status_ff;

endmodule

// File: sv/trimmed_mean_drop_extremes_core.sv
// Path: a full group's result goes from its marked beat through the queue, back-end pop, trim,
// magnitude, 48 one-bit divide steps and the output register; short or overlong groups skip trim to divide.
// Throughput: one sample per cycle while the queue has room; the back end takes one group at a
// time, so groups closing faster than it finishes them fill the 2-deep queue and stall the input.
// Reset: synchronous, active high; clears accumulators, queue and result valid.
module trimmed_mean_drop_extremes_core
   import tmde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_mean,
   output logic [STATUS_W-1:0]        rsp_status
);

   logic    q_push;
   logic    q_full;
   job_type push_job;
   job_type pop_job;
   logic    q_empty;
   logic    q_pop;

   // Accumulate samples and close groups
   tmde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // Finished groups waiting for the divider
   tmde_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .full   (q_full),
      .wr_job (push_job),
      .pop    (q_pop),
      .empty  (q_empty),
      .rd_job (pop_job)
   );

   // Trim, divide and deliver
   tmde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_mean   (rsp_mean),
      .rsp_status (rsp_status)
   );

endmodule
